FILE: src/plist_pkg.sv
// Shared codes, field widths and the result record of the positional list engine.
package plist_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int POSITION_W = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 9;

    localparam logic [REQ_TYPE_W-1:0] OP_INSERT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] OP_GET    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] OP_FIND   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [POSITION_W-1:0]     found_position;
        logic [LENGTH_W-1:0]       list_length;
    } plist_result_t;

endpackage

FILE: src/plist_if.sv
// Request and response channel interfaces of the positional list engine.
interface plist_req_if
    import plist_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_TYPE_W-1:0]     req_type;
    logic [POSITION_W-1:0]     position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface plist_rsp_if
    import plist_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [POSITION_W-1:0]     found_position;
    logic [LENGTH_W-1:0]       list_length;

    modport source (output valid, status, read_value, found_position, list_length,
                    input ready);
    modport sink   (input valid, status, read_value, found_position, list_length,
                    output ready);
endinterface

FILE: src/plist_ram.sv
// Entry store: one write port, one read port with registered read data.
module plist_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/positional_list_engine.sv
// Positional list engine: ordered list of words kept in one single-port-read RAM.
// Insert moves the entries from the position to the tail up by one, tail first, then writes
// the word; remove moves the entries above the position down by one; find reads from entry 0
// upward and stops at the first match. Update writes in place and get reads the one entry.
// Throughput: one request at a time; the next is taken once the result is staged,
// bounded by the one-entry-per-cycle RAM read port used for shifting and searching.
// Reset: asynchronous, clears the length and all control; list contents stay undefined.
module positional_list_engine
    import plist_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_GETW = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH-1:0] w;
        w = '0;
        for (int i = 0; i < MW; i++)
        begin
            w[i] = v[i];
        end
        return w;
    endfunction

    function automatic logic [VALUE_W-1:0] to_field(input logic [DATA_WIDTH-1:0] w);
        logic [VALUE_W-1:0] v;
        v = '0;
        for (int i = 0; i < MW; i++)
        begin
            v[i] = w[i];
        end
        return v;
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         cursor_reg, cursor_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    plist_result_t         res_reg, res_next;
    plist_result_t         out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [LENGTH_W-1:0]   req_pos_ext;
    logic [LENGTH_W-1:0]   count_ext;

    plist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_pos_ext = LENGTH_W'(req.position);
    assign count_ext   = LENGTH_W'(count_reg);
    assign req.ready   = (state_reg == S_IDLE);

    // Shifts read one side of the cursor and write the other, and a request is
    // taken only after the previous one finished writing, so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        pend_next      = pend_reg;
        wr_addr_next   = wr_addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pos_next   = AW'(req.position);
                    val_next   = to_word(req.value);
                    res_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    unique case (req.req_type)
                        OP_INSERT:
                        begin
                            if (req_pos_ext > count_ext)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                cursor_next = count_reg;
                                state_next  = S_INS;
                            end
                        end
                        OP_REMOVE, OP_GET, OP_UPDATE:
                        begin
                            if (req_pos_ext >= count_ext)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else if (req.req_type == OP_REMOVE)
                            begin
                                cursor_next = CW'(req.position);
                                state_next  = S_REM;
                            end
                            else if (req.req_type == OP_GET)
                            begin
                                ram_raddr  = AW'(req.position);
                                state_next = S_GETW;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(req.position);
                                ram_wdata = to_word(req.value);
                            end
                        end
                        OP_FIND:
                        begin
                            cursor_next = '0;
                            state_next  = S_FIND;
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (cursor_reg > CW'(pos_reg))
                begin
                    // move entry cursor-1 up to cursor
                    ram_raddr    = AW'(cursor_reg - 1'b1);
                    wr_addr_next = cursor_reg[AW-1:0];
                    pend_next    = 1'b1;
                    cursor_next  = cursor_reg - 1'b1;
                end
                else if (!pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_REM:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if ((CW+1)'(cursor_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    // move entry cursor+1 down to cursor
                    ram_raddr    = AW'(cursor_reg + 1'b1);
                    wr_addr_next = cursor_reg[AW-1:0];
                    pend_next    = 1'b1;
                    cursor_next  = cursor_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_GETW:
            begin
                res_next.read_value = to_field(ram_rdata);
                state_next          = S_DONE;
            end

            S_FIND:
            begin
                if (pend_reg && (ram_rdata == val_reg))
                begin
                    res_next.status         = ST_OK;
                    res_next.read_value     = to_field(ram_rdata);
                    res_next.found_position = POSITION_W'(wr_addr_reg);
                    pend_next               = 1'b0;
                    state_next              = S_DONE;
                end
                else if (cursor_reg < count_reg)
                begin
                    // issue the next read, compare it in the following cycle
                    ram_raddr    = cursor_reg[AW-1:0];
                    wr_addr_next = cursor_reg[AW-1:0];
                    pend_next    = 1'b1;
                    cursor_next  = cursor_reg + 1'b1;
                end
                else
                begin
                    res_next.status = ST_MISSING;
                    pend_next       = 1'b0;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next             = res_reg;
                    out_next.list_length = count_ext;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.read_value     = out_reg.read_value;
    assign rsp.found_position = out_reg.found_position;
    assign rsp.list_length    = out_reg.list_length;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg + 1'b1 == $past(count_reg)))
        else $error("list length moved by more than one");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.list_length == LENGTH_W'(CAPACITY)))
        else $error("full status reported on a list that is not full");

    a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("result left while output register still occupied");
`endif

endmodule
